// ===== sv/link_heartbeat_supervisor_defines.svh =====
// ----------------------------------------------------------------------------
// Link heartbeat supervisor: assertion macros
// Clocked on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef LINK_HEARTBEAT_SUPERVISOR_DEFINES_SVH
`define LINK_HEARTBEAT_SUPERVISOR_DEFINES_SVH

// same-cycle implication
`define LHS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lhs_pkg.sv =====
// ----------------------------------------------------------------------------
// lhs_pkg
// Types, codes and constants shared by the link heartbeat supervisor.
// ----------------------------------------------------------------------------
package lhs_pkg;

  localparam int CHANNELS   = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = IDX_W + 1;
  localparam int TIME_W     = 32;
  localparam int TMO_W      = 20;
  localparam int MISS_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [MISS_W-1:0] MIN_CHECK_LIMIT = 8'd10;
  localparam logic [MISS_W-1:0] MISS_MAX        = 8'hFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONN_TIMEOUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_LIMIT   = 3'd5;

  // register reset values
  localparam logic [CNT_W-1:0]  RST_CHANNEL_COUNT = 5'd16;
  localparam logic [TMO_W-1:0]  RST_IDLE_TIMEOUT  = 20'd10000;
  localparam logic [TMO_W-1:0]  RST_REPLY_TIMEOUT = 20'd5000;
  localparam logic [TMO_W-1:0]  RST_CONN_TIMEOUT  = 20'd30000;
  localparam logic [TMO_W-1:0]  RST_RETRY_DELAY   = 20'd5000;
  localparam logic [MISS_W-1:0] RST_CHECK_LIMIT   = 8'd10;

  // input functions
  localparam logic [2:0] FUNC_TICK      = 3'd0;
  localparam logic [2:0] FUNC_CONN_OK   = 3'd1;
  localparam logic [2:0] FUNC_CONN_FAIL = 3'd2;
  localparam logic [2:0] FUNC_HB_REPLY  = 3'd3;
  localparam logic [2:0] FUNC_LINK_LOST = 3'd4;

  // commands
  localparam logic [1:0] CMD_RECONNECT = 2'd0;
  localparam logic [1:0] CMD_HEARTBEAT = 2'd1;
  localparam logic [1:0] CMD_DEAD      = 2'd2;

  typedef enum logic [2:0] {
    MODE_DISC,
    MODE_CONN,
    MODE_IDLE,
    MODE_CHECK,
    MODE_WAIT
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVENT,
    ST_SWEEP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [2:0]       func;
    logic [IDX_W-1:0] channel;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_channel;
    logic [1:0]       command;
    logic             last;
  } out_item_t;

  typedef struct packed {
    mode_t             mode;
    logic [TIME_W-1:0] stamp;
    logic [MISS_W-1:0] missed;
  } chan_entry_t;

  localparam chan_entry_t ENTRY_RESET = '{mode: MODE_DISC, stamp: '0, missed: '0};

  typedef struct packed {
    logic [CNT_W-1:0]  channel_count;
    logic [TMO_W-1:0]  idle_timeout_ms;
    logic [TMO_W-1:0]  reply_timeout_ms;
    logic [TMO_W-1:0]  connect_timeout_ms;
    logic [TMO_W-1:0]  retry_delay_ms;
    logic [MISS_W-1:0] check_limit;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    chan_entry_t      entry;
  } mem_wr_t;

  typedef struct packed {
    chan_entry_t entry;
    logic        emit;
    logic [1:0]  cmd;
  } upd_t;

endpackage

// ===== sv/lhs_chan_table.sv =====
// ----------------------------------------------------------------------------
// lhs_chan_table
// Channel table: one-port-read, one-port-write synchronous memory with
// per-entry valid flags so that unwritten entries read as the reset entry.
// ----------------------------------------------------------------------------
module lhs_chan_table (
  input  logic                 clk,
  input  logic                 rst,
  input  lhs_pkg::mem_rd_t     rd,
  input  lhs_pkg::mem_wr_t     wr,
  output lhs_pkg::chan_entry_t rd_entry
);

  lhs_pkg::chan_entry_t             mem [lhs_pkg::CHANNELS];
  logic [lhs_pkg::CHANNELS-1:0]     valid;
  lhs_pkg::chan_entry_t             rd_q;
  logic                             rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    if (rd.en) begin
      rd_q     <= mem[rd.addr];
      rd_valid <= valid[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  assign rd_entry = rd_valid ? rd_q : lhs_pkg::ENTRY_RESET;

endmodule

// ===== sv/lhs_chan_update.sv =====
// ----------------------------------------------------------------------------
// lhs_chan_update
// Per-channel tick rule: picks the timeout for the mode, checks elapsed time
// and returns the new entry and any command.
// ----------------------------------------------------------------------------
module lhs_chan_update (
  input  lhs_pkg::chan_entry_t        entry,
  input  logic [lhs_pkg::TIME_W-1:0]  now,
  input  lhs_pkg::cfg_t               cfg,
  output lhs_pkg::upd_t               res
);

  logic [lhs_pkg::TMO_W-1:0]  tmo;
  logic [lhs_pkg::TIME_W-1:0] elapsed;
  logic                       timed_out;
  logic [lhs_pkg::MISS_W-1:0] limit;

  always_comb begin
    case (entry.mode)
      lhs_pkg::MODE_DISC: tmo = cfg.retry_delay_ms;
      lhs_pkg::MODE_IDLE: tmo = cfg.idle_timeout_ms;
      lhs_pkg::MODE_WAIT: tmo = cfg.reply_timeout_ms;
      lhs_pkg::MODE_CONN: tmo = cfg.connect_timeout_ms;
      default:            tmo = '0;
    endcase
  end

  // elapsed wraps modulo 2^32
  assign elapsed   = now - entry.stamp;
  assign timed_out = elapsed >= {{(lhs_pkg::TIME_W-lhs_pkg::TMO_W){1'b0}}, tmo};
  assign limit     = (cfg.check_limit < lhs_pkg::MIN_CHECK_LIMIT) ?
                     lhs_pkg::MIN_CHECK_LIMIT : cfg.check_limit;

  always_comb begin
    res.entry = entry;
    res.emit  = 1'b0;
    res.cmd   = lhs_pkg::CMD_RECONNECT;
    case (entry.mode)
      lhs_pkg::MODE_DISC: begin
        if (timed_out) begin
          res.emit        = 1'b1;
          res.cmd         = lhs_pkg::CMD_RECONNECT;
          res.entry.mode  = lhs_pkg::MODE_CONN;
          res.entry.stamp = now;
        end
      end
      lhs_pkg::MODE_IDLE: begin
        if (timed_out) begin
          res.entry.mode = lhs_pkg::MODE_CHECK;
        end
      end
      lhs_pkg::MODE_CHECK: begin
        res.emit = 1'b1;
        if (entry.missed >= limit) begin
          res.cmd          = lhs_pkg::CMD_DEAD;
          res.entry.mode   = lhs_pkg::MODE_DISC;
          res.entry.missed = '0;
        end else begin
          res.cmd         = lhs_pkg::CMD_HEARTBEAT;
          res.entry.mode  = lhs_pkg::MODE_WAIT;
          res.entry.stamp = now;
        end
      end
      lhs_pkg::MODE_WAIT: begin
        if (timed_out) begin
          res.entry.mode = lhs_pkg::MODE_CHECK;
          if (entry.missed != lhs_pkg::MISS_MAX) begin
            res.entry.missed = entry.missed + 1'b1;
          end
        end
      end
      lhs_pkg::MODE_CONN: begin
        if (timed_out) begin
          res.entry.mode = lhs_pkg::MODE_DISC;
        end
      end
      default: begin
        res.entry = entry;
      end
    endcase
  end

endmodule

// ===== sv/link_heartbeat_supervisor.sv =====
// ----------------------------------------------------------------------------
// link_heartbeat_supervisor
// Keeps a table of link channels in a synchronous memory; ticks sweep the
// table with read-modify-write and issue reconnect/heartbeat/dead commands.
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall   in_data  (func, channel)
//   out      out  out_valid / out_stall out_data (out_channel, command, last)
//   cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A tick sweeps min(channel_count, 16) entries, one per cycle through the
// table's read port unless paused, each written back after its read; a flush
// state releases the final command with last set. An event is a read and a
// write-back. A tick with no channel in use, and any ignored item, stays idle.
// A stalled output pauses the sweep when a further command comes up while one
// sits in the output register and one is parked; the last one waits likewise.
// Synchronous reset; the table comes out of reset via its valid flags.
// ----------------------------------------------------------------------------
`include "link_heartbeat_supervisor_defines.svh"

module link_heartbeat_supervisor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lhs_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lhs_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lhs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lhs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  lhs_pkg::state_t             state, state_next;
  lhs_pkg::cfg_t               cfg;
  logic [lhs_pkg::TIME_W-1:0]  now;
  logic [lhs_pkg::IDX_W-1:0]   idx;
  logic [2:0]                  ev_func;
  logic                        pend_valid;
  logic [lhs_pkg::IDX_W-1:0]   pend_channel;
  logic [1:0]                  pend_cmd;

  lhs_pkg::mem_rd_t            rd;
  lhs_pkg::mem_wr_t            wr;
  lhs_pkg::chan_entry_t        rd_entry;
  lhs_pkg::upd_t               upd;

  logic [lhs_pkg::CNT_W-1:0]   used;
  logic [lhs_pkg::CNT_W-1:0]   idx_inc;
  logic                        accept;
  logic                        tick_start;
  logic                        ev_start;
  logic                        out_free;
  logic                        go;
  logic                        more;
  logic                        load_out;
  logic                        load_last;
  logic                        pend_take;

  lhs_chan_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd       (rd),
    .wr       (wr),
    .rd_entry (rd_entry)
  );

  lhs_chan_update u_update (
    .entry (rd_entry),
    .now   (now),
    .cfg   (cfg),
    .res   (upd)
  );

  assign used = (cfg.channel_count > lhs_pkg::CNT_W'(lhs_pkg::CHANNELS)) ?
                lhs_pkg::CNT_W'(lhs_pkg::CHANNELS) : cfg.channel_count;
  assign idx_inc   = {1'b0, idx} + 1'b1;
  assign more      = idx_inc < used;
  assign in_stall  = (state != lhs_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // outputs / datapath control
  always_comb begin
    tick_start = 1'b0;
    ev_start   = 1'b0;
    go         = 1'b0;
    load_out   = 1'b0;
    load_last  = 1'b0;
    pend_take  = 1'b0;
    rd         = '0;
    wr         = '0;
    case (state)
      lhs_pkg::ST_IDLE: begin
        if (accept) begin
          tick_start = (in_data.func == lhs_pkg::FUNC_TICK) && (used != '0);
          ev_start   = (in_data.func inside {[lhs_pkg::FUNC_CONN_OK:lhs_pkg::FUNC_LINK_LOST]})
                       && ({1'b0, in_data.channel} < used);
        end
        rd.en   = tick_start || ev_start;
        rd.addr = tick_start ? '0 : in_data.channel;
      end
      lhs_pkg::ST_EVENT: begin
        wr.en          = 1'b1;
        wr.addr        = idx;
        wr.entry       = rd_entry;
        wr.entry.stamp = now;
        case (ev_func)
          lhs_pkg::FUNC_CONN_OK: wr.entry.mode = lhs_pkg::MODE_IDLE;
          lhs_pkg::FUNC_HB_REPLY: begin
            wr.entry.mode   = lhs_pkg::MODE_IDLE;
            wr.entry.missed = '0;
          end
          default: wr.entry.mode = lhs_pkg::MODE_DISC;
        endcase
      end
      lhs_pkg::ST_SWEEP: begin
        // a new command can only park if the held one can move on
        go = !(upd.emit && pend_valid && !out_free);
        if (go) begin
          wr.en     = 1'b1;
          wr.addr   = idx;
          wr.entry  = upd.entry;
          load_out  = upd.emit && pend_valid;
          rd.en     = more;
          rd.addr   = idx_inc[lhs_pkg::IDX_W-1:0];
        end
      end
      lhs_pkg::ST_FLUSH: begin
        if (pend_valid && out_free) begin
          load_out  = 1'b1;
          load_last = 1'b1;
          pend_take = 1'b1;
        end
      end
      default: begin
        go = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lhs_pkg::ST_IDLE: begin
        if (tick_start) begin
          state_next = lhs_pkg::ST_SWEEP;
        end else if (ev_start) begin
          state_next = lhs_pkg::ST_EVENT;
        end
      end
      lhs_pkg::ST_EVENT: state_next = lhs_pkg::ST_IDLE;
      lhs_pkg::ST_SWEEP: begin
        if (go && !more) begin
          state_next = lhs_pkg::ST_FLUSH;
        end
      end
      lhs_pkg::ST_FLUSH: begin
        if (!pend_valid || pend_take) begin
          state_next = lhs_pkg::ST_IDLE;
        end
      end
      default: state_next = lhs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                  <= lhs_pkg::ST_IDLE;
      now                    <= '0;
      pend_valid             <= 1'b0;
      out_valid              <= 1'b0;
      cfg.channel_count      <= lhs_pkg::RST_CHANNEL_COUNT;
      cfg.idle_timeout_ms    <= lhs_pkg::RST_IDLE_TIMEOUT;
      cfg.reply_timeout_ms   <= lhs_pkg::RST_REPLY_TIMEOUT;
      cfg.connect_timeout_ms <= lhs_pkg::RST_CONN_TIMEOUT;
      cfg.retry_delay_ms     <= lhs_pkg::RST_RETRY_DELAY;
      cfg.check_limit        <= lhs_pkg::RST_CHECK_LIMIT;
    end else begin
      state <= state_next;
      if (accept && in_data.func == lhs_pkg::FUNC_TICK) begin
        now <= now + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lhs_pkg::CFG_CHANNEL_COUNT: cfg.channel_count      <= cfg_data[lhs_pkg::CNT_W-1:0];
          lhs_pkg::CFG_IDLE_TIMEOUT:  cfg.idle_timeout_ms    <= cfg_data;
          lhs_pkg::CFG_REPLY_TIMEOUT: cfg.reply_timeout_ms   <= cfg_data;
          lhs_pkg::CFG_CONN_TIMEOUT:  cfg.connect_timeout_ms <= cfg_data;
          lhs_pkg::CFG_RETRY_DELAY:   cfg.retry_delay_ms     <= cfg_data;
          lhs_pkg::CFG_CHECK_LIMIT:   cfg.check_limit        <= cfg_data[lhs_pkg::MISS_W-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == lhs_pkg::ST_SWEEP && go && upd.emit) begin
        pend_valid <= 1'b1;
      end else if (pend_take) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick_start) begin
      idx <= '0;
    end else if (ev_start) begin
      idx <= in_data.channel;
    end else if (state == lhs_pkg::ST_SWEEP && go && more) begin
      idx <= idx_inc[lhs_pkg::IDX_W-1:0];
    end
    if (ev_start) begin
      ev_func <= in_data.func;
    end
    if (load_out) begin
      out_data.out_channel <= pend_channel;
      out_data.command     <= pend_cmd;
      out_data.last        <= load_last;
    end
    if (state == lhs_pkg::ST_SWEEP && go && upd.emit) begin
      pend_channel <= idx;
      pend_cmd     <= upd.cmd;
    end
  end

  `LHS_ASSERT_IMP(a_idle_no_pending, state == lhs_pkg::ST_IDLE, !pend_valid,
                  "held command left over after a tick")
  `LHS_ASSERT_NEXT(a_sweep_hold, state == lhs_pkg::ST_SWEEP && !go,
                   state == lhs_pkg::ST_SWEEP && idx == $past(idx),
                   "sweep moved on while blocked")
  `LHS_ASSERT_NEXT(a_flush_last, state == lhs_pkg::ST_FLUSH && pend_valid && out_free,
                   out_valid && out_data.last,
                   "final command of a tick not marked last")
  `LHS_ASSERT_IMP(a_write_no_read_clash, wr.en && rd.en, wr.addr != rd.addr,
                  "read and write of the same entry in one cycle")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Link heartbeat supervisor testbench
// Drives event and tick transfers into the supervisor and follows every
// channel's mode, stamp and miss count in a local copy of the table. Each
// tick's commands are predicted in sweep order and checked against the output
// transfers. Both handshakes see random idle bursts. The register settings
// change between phases, once the block has gone quiet.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WATCHDOG_CYCLES = 400000;
  localparam int          SETTLE_CYCLES   = lhs_pkg::CHANNELS + 8;
  localparam int          MAX_REPORTS     = 10;
  localparam logic [2:0]  FUNC_TOP        = 3'd7;   // highest func code the port carries
  // index with no register behind it
  localparam logic [lhs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  lhs_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  lhs_pkg::out_item_t             out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [lhs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lhs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  link_heartbeat_supervisor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // local copy of the supervisor's table and registers
  lhs_pkg::mode_t                chan_mode   [lhs_pkg::CHANNELS];
  logic [lhs_pkg::TIME_W-1:0]    chan_stamp  [lhs_pkg::CHANNELS];
  logic [lhs_pkg::MISS_W-1:0]    chan_missed [lhs_pkg::CHANNELS];
  logic [lhs_pkg::TIME_W-1:0]    clock_ms;
  logic [lhs_pkg::CNT_W-1:0]     n_channels;
  logic [lhs_pkg::TMO_W-1:0]     idle_tmo, reply_tmo, conn_tmo, retry_tmo;
  logic [lhs_pkg::MISS_W-1:0]    miss_limit;

  lhs_pkg::in_item_t  item_backlog [$];
  lhs_pkg::out_item_t pending_cmds [$];
  int                 items_queued = 0;
  int                 items_taken  = 0;
  int                 fail_count   = 0;
  int                 cycles       = 0;
  int                 phases_run   = 0;
  int                 cmd_seen [3] = '{0, 0, 0};
  logic               in_took = 1'b0;
  logic               calm = 1'b0;
  int                 in_gap = 0;
  int                 out_gap = 0;
  lhs_pkg::out_item_t mon_got, mon_want;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  task automatic issue(input int ch, input logic [1:0] code);
    lhs_pkg::out_item_t cmd;
    cmd = '{out_channel: lhs_pkg::IDX_W'(ch), command: code, last: 1'b0};
    pending_cmds = {pending_cmds, cmd};
  endtask

  task automatic predict_commands(input lhs_pkg::in_item_t it);
    int                         used;
    int                         before_sweep;
    logic [lhs_pkg::MISS_W-1:0] lim;
    logic [lhs_pkg::TIME_W-1:0] span;
    lhs_pkg::out_item_t         tail;
    used = (n_channels > lhs_pkg::CHANNELS) ? lhs_pkg::CHANNELS : int'(n_channels);
    lim  = (miss_limit < lhs_pkg::MIN_CHECK_LIMIT) ? lhs_pkg::MIN_CHECK_LIMIT : miss_limit;
    if (it.func == lhs_pkg::FUNC_TICK) begin
      clock_ms++;
      before_sweep = pending_cmds.size();
      for (int i = 0; i < used; i++) begin
        span = clock_ms - chan_stamp[i];
        case (chan_mode[i])
          lhs_pkg::MODE_DISC: if (span >= retry_tmo) begin
            issue(i, lhs_pkg::CMD_RECONNECT);
            chan_mode[i]  = lhs_pkg::MODE_CONN;
            chan_stamp[i] = clock_ms;
          end
          lhs_pkg::MODE_IDLE: if (span >= idle_tmo) chan_mode[i] = lhs_pkg::MODE_CHECK;
          lhs_pkg::MODE_CHECK: if (chan_missed[i] >= lim) begin
            issue(i, lhs_pkg::CMD_DEAD);
            chan_mode[i]   = lhs_pkg::MODE_DISC;
            chan_missed[i] = '0;
          end else begin
            issue(i, lhs_pkg::CMD_HEARTBEAT);
            chan_mode[i]  = lhs_pkg::MODE_WAIT;
            chan_stamp[i] = clock_ms;
          end
          lhs_pkg::MODE_WAIT: if (span >= reply_tmo) begin
            chan_mode[i] = lhs_pkg::MODE_CHECK;
            if (chan_missed[i] != lhs_pkg::MISS_MAX) chan_missed[i]++;
          end
          lhs_pkg::MODE_CONN: if (span >= conn_tmo) chan_mode[i] = lhs_pkg::MODE_DISC;
          default: ;
        endcase
      end
      if (pending_cmds.size() > before_sweep) begin
        tail = pending_cmds[pending_cmds.size() - 1];
        tail.last = 1'b1;
        pending_cmds[pending_cmds.size() - 1] = tail;
      end
    end else if (it.func <= lhs_pkg::FUNC_LINK_LOST && it.channel < used) begin
      case (it.func)
        lhs_pkg::FUNC_CONN_OK: chan_mode[it.channel] = lhs_pkg::MODE_IDLE;
        lhs_pkg::FUNC_HB_REPLY: begin
          chan_mode[it.channel]   = lhs_pkg::MODE_IDLE;
          chan_missed[it.channel] = '0;
        end
        default: chan_mode[it.channel] = lhs_pkg::MODE_DISC;
      endcase
      chan_stamp[it.channel] = clock_ms;
    end
  endtask

  task automatic flag_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
  endtask

  // ------------------------------------------------------------------ drivers
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 15) begin
        in_gap = $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (item_backlog.size() > 0) begin
        in_data  <= item_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 15) begin
      out_gap = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_commands(in_data);
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        mon_got = out_data;
        if (pending_cmds.size() == 0) begin
          flag_mismatch($sformatf("unexpected command transfer: ch %0d cmd %0d last %0d",
                                  mon_got.out_channel, mon_got.command, mon_got.last));
        end else begin
          mon_want = pending_cmds.pop_front();
          cmd_seen[mon_want.command]++;
          if (mon_got.out_channel !== mon_want.out_channel ||
              mon_got.command !== mon_want.command || mon_got.last !== mon_want.last)
            flag_mismatch($sformatf(
              "command: expected ch %0d cmd %0d last %0d, got ch %0d cmd %0d last %0d",
              mon_want.out_channel, mon_want.command, mon_want.last,
              mon_got.out_channel, mon_got.command, mon_got.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > WATCHDOG_CYCLES) begin
      $display("timeout after %0d cycles, %0d commands outstanding",
               cycles, pending_cmds.size());
      $display("link_heartbeat_supervisor: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic write_reg(input logic [lhs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lhs_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lhs_pkg::CFG_CHANNEL_COUNT: n_channels = val[lhs_pkg::CNT_W-1:0];
      lhs_pkg::CFG_IDLE_TIMEOUT:  idle_tmo   = val[lhs_pkg::TMO_W-1:0];
      lhs_pkg::CFG_REPLY_TIMEOUT: reply_tmo  = val[lhs_pkg::TMO_W-1:0];
      lhs_pkg::CFG_CONN_TIMEOUT:  conn_tmo   = val[lhs_pkg::TMO_W-1:0];
      lhs_pkg::CFG_RETRY_DELAY:   retry_tmo  = val[lhs_pkg::TMO_W-1:0];
      lhs_pkg::CFG_CHECK_LIMIT:   miss_limit = val[lhs_pkg::MISS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits carry noise
  task automatic configure(input int cnt, idle, reply, conn, retry, lim);
    write_reg(lhs_pkg::CFG_CHANNEL_COUNT, {15'($urandom), 5'(cnt)});
    write_reg(lhs_pkg::CFG_IDLE_TIMEOUT, 20'(idle));
    write_reg(lhs_pkg::CFG_REPLY_TIMEOUT, 20'(reply));
    write_reg(lhs_pkg::CFG_CONN_TIMEOUT, 20'(conn));
    write_reg(lhs_pkg::CFG_RETRY_DELAY, 20'(retry));
    write_reg(lhs_pkg::CFG_CHECK_LIMIT, {12'($urandom), 8'(lim)});
  endtask

  task automatic queue_item(input logic [2:0] f, input logic [lhs_pkg::IDX_W-1:0] c);
    lhs_pkg::in_item_t it;
    it = '{func: f, channel: c};
    item_backlog = {item_backlog, it};
    items_queued++;
  endtask

  // events and unknown codes leave nothing to wait for, so give the sweep time
  task automatic drain();
    while (items_taken != items_queued || pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    phases_run++;
  endtask

  task automatic random_phase(input int quota, input int tick_pct);
    int                        counted;
    int                        used;
    int                        r;
    logic [2:0]                f;
    logic [lhs_pkg::IDX_W-1:0] c;
    counted = 0;
    used = (n_channels > lhs_pkg::CHANNELS) ? lhs_pkg::CHANNELS : int'(n_channels);
    while (counted < quota) begin
      r = $urandom_range(0, 99);
      c = lhs_pkg::IDX_W'($urandom);
      if (r < tick_pct) begin
        f = lhs_pkg::FUNC_TICK;
      end else if (r < 96) begin
        f = 3'($urandom_range(lhs_pkg::FUNC_CONN_OK, lhs_pkg::FUNC_LINK_LOST));
        if ($urandom_range(0, 9) != 0) c = lhs_pkg::IDX_W'($urandom_range(0, used - 1));
      end else begin
        f = 3'($urandom_range(lhs_pkg::FUNC_LINK_LOST + 1, FUNC_TOP));
      end
      queue_item(f, c);
      if (f == lhs_pkg::FUNC_TICK || (f <= lhs_pkg::FUNC_LINK_LOST && c < used)) counted++;
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < lhs_pkg::CHANNELS; i++) begin
      chan_mode[i]   = lhs_pkg::MODE_DISC;
      chan_stamp[i]  = '0;
      chan_missed[i] = '0;
    end
    clock_ms   = '0;
    n_channels = lhs_pkg::RST_CHANNEL_COUNT;
    idle_tmo   = lhs_pkg::RST_IDLE_TIMEOUT;
    reply_tmo  = lhs_pkg::RST_REPLY_TIMEOUT;
    conn_tmo   = lhs_pkg::RST_CONN_TIMEOUT;
    retry_tmo  = lhs_pkg::RST_RETRY_DELAY;
    miss_limit = lhs_pkg::RST_CHECK_LIMIT;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: long timeouts, events on the edge channels, unknown codes
    queue_item(lhs_pkg::FUNC_TICK, 4'hF);
    queue_item(lhs_pkg::FUNC_CONN_OK, 4'h0);
    queue_item(lhs_pkg::FUNC_HB_REPLY, 4'hF);
    queue_item(lhs_pkg::FUNC_CONN_FAIL, 4'h3);
    queue_item(lhs_pkg::FUNC_LINK_LOST, 4'h7);
    queue_item(3'(lhs_pkg::FUNC_LINK_LOST + 1), 4'hA);
    queue_item(FUNC_TOP, 4'h5);
    queue_item(lhs_pkg::FUNC_TICK, 4'h0);
    drain();

    // no channel in use: ticks only move time on
    configure(0, 1, 1, 1, 1, lhs_pkg::MIN_CHECK_LIMIT);
    queue_item(lhs_pkg::FUNC_TICK, 4'h0);
    queue_item(lhs_pkg::FUNC_CONN_OK, 4'h0);
    queue_item(lhs_pkg::FUNC_TICK, 4'h9);
    drain();

    // one channel, zero timeouts, limit below the floor
    configure(1, 0, 0, 0, 0, 0);
    write_reg(CFG_SPARE, {lhs_pkg::TMO_W{1'b1}});
    queue_item(lhs_pkg::FUNC_LINK_LOST, 4'h0);  // back to disconnected
    queue_item(lhs_pkg::FUNC_TICK, 4'h0);       // reconnect
    queue_item(lhs_pkg::FUNC_TICK, 4'h0);       // connect times out
    queue_item(lhs_pkg::FUNC_TICK, 4'h0);       // reconnect again
    queue_item(lhs_pkg::FUNC_CONN_OK, 4'h0);
    queue_item(lhs_pkg::FUNC_CONN_OK, 4'h1);    // channel not in use
    queue_item(lhs_pkg::FUNC_TICK, 4'h0);       // idle -> check
    queue_item(lhs_pkg::FUNC_TICK, 4'h0);       // heartbeat
    queue_item(lhs_pkg::FUNC_TICK, 4'h0);       // miss
    queue_item(lhs_pkg::FUNC_HB_REPLY, 4'h0);
    queue_item(lhs_pkg::FUNC_TICK, 4'h0);
    queue_item(lhs_pkg::FUNC_LINK_LOST, 4'h0);
    queue_item(lhs_pkg::FUNC_CONN_FAIL, 4'h0);
    queue_item(lhs_pkg::FUNC_TICK, 4'h0);
    drain();

    configure(16, $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
              $urandom_range(0, 3), lhs_pkg::MIN_CHECK_LIMIT);
    random_phase(60, 85);
    configure(31, $urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 2),
              $urandom_range(0, 2), 0);
    random_phase(60, 90);
    configure($urandom_range(1, 16), $urandom_range(0, 6), $urandom_range(0, 6),
              $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(10, 20));
    random_phase(60, 70);
    configure(16, {lhs_pkg::TMO_W{1'b1}}, 0, {lhs_pkg::TMO_W{1'b1}}, 1, lhs_pkg::MISS_MAX);
    random_phase(60, 60);
    configure($urandom_range(17, 30), $urandom_range(1, 3), $urandom_range(1, 3),
              $urandom_range(1, 3), $urandom_range(1, 3), 9);
    random_phase(60, 80);
    calm = 1'b1;
    configure(16, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
              $urandom_range(0, 1), $urandom_range(10, 12));
    random_phase(60, 85);

    $display("%0d input transfers over %0d register settings, %0d ms of ticks",
             items_taken, phases_run, clock_ms);
    $display("commands checked: %0d reconnect, %0d heartbeat, %0d link dead",
             cmd_seen[lhs_pkg::CMD_RECONNECT], cmd_seen[lhs_pkg::CMD_HEARTBEAT],
             cmd_seen[lhs_pkg::CMD_DEAD]);
    if (fail_count == 0) begin
      $display("link_heartbeat_supervisor: match");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("link_heartbeat_supervisor: mismatch");
    end
    $finish;
  end

endmodule
